/* src/vector_refract_core_assert.svh */
// Assertion macros shared by the RTL.
`ifndef VECTOR_REFRACT_CORE_ASSERT_SVH
`define VECTOR_REFRACT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// a |-> b on every rising clock edge outside reset
`define VR_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// a |=> b on every rising clock edge outside reset
`define VR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define VR_ASSERT_IMP(label, clk, rst, a, b)
`define VR_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

/* src/vr_pkg.sv */
`timescale 1ns / 1ps
package vr_pkg;

  localparam int WIDTH     = 16;
  localparam int FRAC_BITS = 12;
  localparam int INTER_W   = 32;
  // root of a nonnegative intermediate shifted left by FRAC_BITS
  localparam int ROOT_W    = (INTER_W - 1 + FRAC_BITS + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam longint INTER_MAX = (64'sd1 <<< (INTER_W - 1)) - 64'sd1;

  typedef logic signed [INTER_W-1:0] inter_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] inc_x;
    logic signed [WIDTH-1:0] inc_y;
    logic signed [WIDTH-1:0] inc_z;
    logic signed [WIDTH-1:0] nrm_x;
    logic signed [WIDTH-1:0] nrm_y;
    logic signed [WIDTH-1:0] nrm_z;
    logic [WIDTH-2:0]        ratio;
  } vec_item_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] out_x;
    logic signed [WIDTH-1:0] out_y;
    logic signed [WIDTH-1:0] out_z;
    logic                    tir;
  } ray_item_t;

  // add half an lsb, then floor-shift by FRAC_BITS
  function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
    logic signed [63:0] h;
    h = v + (64'sd1 <<< (FRAC_BITS - 1));
    return h >>> FRAC_BITS;
  endfunction

  // symmetric saturation of intermediates
  function automatic inter_t sat_inter(input logic signed [63:0] v);
    if (v > INTER_MAX) return inter_t'(INTER_MAX);
    if (v < -INTER_MAX) return inter_t'(-INTER_MAX);
    return inter_t'(v);
  endfunction

endpackage

/* src/vr_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module vr_sqrt #(
  parameter int RAD_W  = vr_pkg::RAD_W,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid,
  input  logic [RAD_W-1:0]     rad,
  input  logic [SIDE_W-1:0]    side,
  output logic                 root_valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [SIDE_W-1:0]    root_side
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    // stage registers
    logic              vld;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] acc;
    logic [RAD_W-1:0]  rad_sh;
    logic [SIDE_W-1:0] tag;

    logic              pv;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] pq;
    logic [RAD_W-1:0]  prad;
    logic [SIDE_W-1:0] pside;
    logic [REM_W-1:0]  remx;
    logic [REM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign pv    = valid;
      assign prem  = '0;
      assign pq    = '0;
      assign prad  = rad;
      assign pside = side;
    end else begin : g_next
      assign pv    = g_stage[j-1].vld;
      assign prem  = g_stage[j-1].rem;
      assign pq    = g_stage[j-1].acc;
      assign prad  = g_stage[j-1].rad_sh;
      assign pside = g_stage[j-1].tag;
    end

    assign remx  = {prem[REM_W-3:0], prad[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, pq, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= pv;
      end
      if (en) begin
        if (remx >= trial) begin
          rem <= remx - trial;
          acc <= {pq[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= remx;
          acc <= {pq[ROOT_W-2:0], 1'b0};
        end
        rad_sh <= {prad[RAD_W-3:0], 2'b00};
        tag    <= pside;
      end
    end
  end

  assign root_valid = g_stage[ROOT_W-1].vld;
  assign root       = g_stage[ROOT_W-1].acc;
  assign root_side  = g_stage[ROOT_W-1].tag;

endmodule

/* src/vector_refract_core.sv */
`timescale 1ns / 1ps
// Snell refraction of an incident vector about a surface normal, Q4.12 fixed
// point: d = n.i, k = 1 - eta^2 (1 - d^2); tir and a zero vector when k < 0,
// else eta*i - (eta*d + sqrt(k))*n, saturated to 16 bits. Fully pipelined:
// one item per cycle while the result side does not stall (5 stages of products
// and rounding, 22 square-root stages at one root bit each, 3 output stages).
// A stall on the result side freezes the whole pipe and is passed straight
// back to vec_stall while a result is waiting.
module vector_refract_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              vec_valid,
  output logic              vec_stall,
  input  vr_pkg::vec_item_t vec,
  output logic              ray_valid,
  input  logic              ray_stall,
  output vr_pkg::ray_item_t ray
);

  localparam int W  = vr_pkg::WIDTH;
  localparam int IW = vr_pkg::INTER_W;
  localparam logic signed [63:0] ONE = 64'sd1 <<< vr_pkg::FRAC_BITS;
  localparam logic signed [63:0] OMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] OMIN = -OMAX - 64'sd1;
  localparam int SIDE_W = 1 + IW + 3 * 2 * W + 3 * W;

  logic en;
  assign en        = !(ray_valid && ray_stall);
  assign vec_stall = ray_valid && ray_stall;

  // valid bits of stages 1..5 and 7..9
  logic [4:0] v;
  logic [2:0] w;

  // stage 1: raw products
  logic signed [2*W-1:0] pi1 [3];
  logic signed [2*W-1:0] ei1 [3];
  logic signed [W-1:0]   n1  [3];
  logic [2*W-3:0]        ee1;
  logic [W-2:0]          eta1;

  // stage 2: d and eta^2
  vr_pkg::inter_t        d2, e2_2;
  logic signed [2*W-1:0] ei2 [3];
  logic signed [W-1:0]   n2  [3];
  logic [W-2:0]          eta2;

  // stage 3
  logic signed [63:0]    dd3, edp3;
  vr_pkg::inter_t        e2_3;
  logic signed [2*W-1:0] ei3 [3];
  logic signed [W-1:0]   n3  [3];

  // stage 4
  vr_pkg::inter_t        t4, ed4, e2_4;
  logic signed [2*W-1:0] ei4 [3];
  logic signed [W-1:0]   n4  [3];

  // stage 5
  logic signed [63:0]    et5;
  vr_pkg::inter_t        ed5;
  logic signed [2*W-1:0] ei5 [3];
  logic signed [W-1:0]   n5  [3];

  // stage 6 (sqrt input)
  vr_pkg::inter_t        k6;
  logic                  tir6;
  logic [vr_pkg::RAD_W-1:0] rad6;
  logic [SIDE_W-1:0]     side6;

  logic                     rv;
  logic [vr_pkg::ROOT_W-1:0] root;
  logic [SIDE_W-1:0]        rside;
  logic                     tir_r;
  vr_pkg::inter_t           ed_r;
  logic signed [2*W-1:0]    ei_r [3];
  logic signed [W-1:0]      n_r  [3];

  // stages 7..9
  vr_pkg::inter_t           s7;
  logic                     tir7, tir8;
  logic signed [2*W-1:0]    ei7 [3];
  logic signed [2*W-1:0]    ei8 [3];
  logic signed [W-1:0]      n7  [3];
  logic signed [IW+W-1:0]   sn8 [3];
  logic signed [W-1:0]      o9  [3];
  logic                     tir9;

  logic signed [W-1:0] vin_i [3];
  logic signed [W-1:0] vin_n [3];
  assign vin_i[0] = vec.inc_x;
  assign vin_i[1] = vec.inc_y;
  assign vin_i[2] = vec.inc_z;
  assign vin_n[0] = vec.nrm_x;
  assign vin_n[1] = vec.nrm_y;
  assign vin_n[2] = vec.nrm_z;

  logic signed [W:0] eta_s;
  assign eta_s = $signed({2'b00, vec.ratio});

  always_comb begin
    k6 = vr_pkg::sat_inter(ONE - 64'(vr_pkg::sat_inter(vr_pkg::round_frac(et5))));
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      w <= '0;
    end else if (en) begin
      v <= {v[3:0], vec_valid};
      w <= {w[1:0], rv};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      for (int c = 0; c < 3; c++) begin
        pi1[c] <= vin_n[c] * vin_i[c];
        ei1[c] <= (2*W)'(eta_s * vin_i[c]);
        n1[c]  <= vin_n[c];
      end
      ee1  <= vec.ratio * vec.ratio;
      eta1 <= vec.ratio;
      // stage 2: one rounding of the exact dot product
      d2   <= vr_pkg::sat_inter(vr_pkg::round_frac(
                64'(pi1[0]) + 64'(pi1[1]) + 64'(pi1[2])));
      e2_2 <= vr_pkg::sat_inter(vr_pkg::round_frac($signed({32'd0, 2'b00, ee1})));
      eta2 <= eta1;
      ei2  <= ei1;
      n2   <= n1;
      // stage 3
      dd3  <= 64'(d2) * 64'(d2);
      edp3 <= $signed({{(64-W+1){1'b0}}, eta2}) * 64'(d2);
      e2_3 <= e2_2;
      ei3  <= ei2;
      n3   <= n2;
      // stage 4
      t4   <= vr_pkg::sat_inter(ONE - 64'(vr_pkg::sat_inter(vr_pkg::round_frac(dd3))));
      ed4  <= vr_pkg::sat_inter(vr_pkg::round_frac(edp3));
      e2_4 <= e2_3;
      ei4  <= ei3;
      n4   <= n3;
      // stage 5
      et5  <= 64'(e2_4) * 64'(t4);
      ed5  <= ed4;
      ei5  <= ei4;
      n5   <= n4;
      // stage 7: s = eta*d + sqrt(k)
      s7   <= vr_pkg::sat_inter(64'(ed_r) +
                $signed({{(64-vr_pkg::ROOT_W){1'b0}}, root}));
      tir7 <= tir_r;
      ei7  <= ei_r;
      n7   <= n_r;
      // stage 8
      for (int c = 0; c < 3; c++) begin
        sn8[c] <= (IW+W)'(s7 * n7[c]);
      end
      ei8  <= ei7;
      tir8 <= tir7;
      // stage 9: round, saturate, zero on tir
      for (int c = 0; c < 3; c++) begin
        logic signed [63:0] q;
        q = vr_pkg::round_frac(64'(ei8[c]) - 64'(sn8[c]));
        if (tir8)         o9[c] <= '0;
        else if (q > OMAX) o9[c] <= W'(OMAX);
        else if (q < OMIN) o9[c] <= W'(OMIN);
        else              o9[c] <= W'(q);
      end
      tir9 <= tir8;
    end
  end

  // stage 6 feeds the root pipe directly from stage 5 registers
  assign tir6  = k6[IW-1];
  assign rad6  = tir6 ? '0 : (vr_pkg::RAD_W'(k6[IW-2:0]) << vr_pkg::FRAC_BITS);
  assign side6 = {tir6, ed5, ei5[0], ei5[1], ei5[2], n5[0], n5[1], n5[2]};

  vr_sqrt #(
    .RAD_W  (vr_pkg::RAD_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .valid      (v[4]),
    .rad        (rad6),
    .side       (side6),
    .root_valid (rv),
    .root       (root),
    .root_side  (rside)
  );

  assign {tir_r, ed_r, ei_r[0], ei_r[1], ei_r[2], n_r[0], n_r[1], n_r[2]} = rside;

  assign ray_valid = w[2];
  assign ray.out_x = o9[0];
  assign ray.out_y = o9[1];
  assign ray.out_z = o9[2];
  assign ray.tir   = tir9;

  `include "vector_refract_core_assert.svh"

  // total internal reflection always comes with a zero vector
  `VR_ASSERT_IMP(a_tir_zero, clk, rst, ray_valid && ray.tir,
                 ray.out_x == '0 && ray.out_y == '0 && ray.out_z == '0)
  // a waiting result holds the input side
  `VR_ASSERT_IMP(a_back_stall, clk, rst, ray_valid && ray_stall, vec_stall)
  // a frozen pipe keeps its result
  `VR_ASSERT_NEXT(a_hold, clk, rst, ray_valid && ray_stall, ray_valid && $stable(ray))

endmodule

/* dv/vector_refract_core_test.sv */
`timescale 1ns / 1ps
// Refraction pipe test: directed corner vectors, a streaming phase with no
// gaps, random rays with random gaps on both sides, a long result-side hold
// that backs the pipe up into vec_stall, and a pause that drains the pipe.
// Every result is checked field by field against a fixed-point predictor.
module vector_refract_core_test;

  localparam longint SAT_MAX   = 64'sd2147483647;
  localparam int     IDLE_LIMIT = 4000;  // cycles with no item moving
  localparam int     FLUSH_WAIT = 40;    // pipe is 30 deep

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              vec_valid = 1'b0;
  logic              vec_stall;
  vr_pkg::vec_item_t vec = '0;
  logic              ray_valid;
  logic              ray_stall = 1'b0;
  vr_pkg::ray_item_t ray;

  vr_pkg::ray_item_t expected_rays[$];
  int        mismatches = 0;
  int        rays_checked = 0;
  int        tir_seen = 0;
  int        rays_sent = 0;
  int        idle_cycles = 0;
  int        hold_cycles = 0;  // one long result-side hold, set by a test
  bit        no_gaps = 1'b0;   // streaming stretch: neither side idles

  vector_refract_core dut (
    .clk(clk), .rst(rst),
    .vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------
  // round half up: add half an lsb, floor-shift (>>> on signed = floor)
  function automatic longint q_round(longint v);
    return (v + (64'sd1 <<< (vr_pkg::FRAC_BITS - 1))) >>> vr_pkg::FRAC_BITS;
  endfunction

  // intermediates clamp to the symmetric 32-bit range
  function automatic longint q_clamp(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < -SAT_MAX) return -SAT_MAX;
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return q_clamp(q_round(a * b));
  endfunction

  // bitwise integer square root
  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic vr_pkg::ray_item_t predict_refraction(vr_pkg::vec_item_t v);
    longint    iv[3], nv[3];
    longint    eta, unit, dp, t, e2, k, s, p, fl, qsum, rsum, o;
    longint    omax, omin;
    vr_pkg::ray_item_t r;
    iv[0] = longint'($signed(v.inc_x));
    iv[1] = longint'($signed(v.inc_y));
    iv[2] = longint'($signed(v.inc_z));
    nv[0] = longint'($signed(v.nrm_x));
    nv[1] = longint'($signed(v.nrm_y));
    nv[2] = longint'($signed(v.nrm_z));
    eta  = longint'(v.ratio);
    unit = 64'sd1 <<< vr_pkg::FRAC_BITS;
    omax = (64'sd1 <<< (vr_pkg::WIDTH - 1)) - 1;
    omin = -omax - 1;
    // dot product: exact sum of full products, rounded once
    qsum = 0;
    rsum = 0;
    for (int c = 0; c < 3; c++) begin
      p    = nv[c] * iv[c];
      fl   = p >>> vr_pkg::FRAC_BITS;
      qsum = qsum + fl;
      rsum = rsum + (p - (fl <<< vr_pkg::FRAC_BITS));
    end
    dp = q_clamp(qsum + q_round(rsum));
    t  = q_clamp(unit - q_mul(dp, dp));
    e2 = q_mul(eta, eta);
    k  = q_clamp(unit - q_mul(e2, t));
    r  = '0;
    if (k < 0) begin
      r.tir = 1'b1;  // total internal reflection: zero vector
      return r;
    end
    s = q_clamp(q_mul(eta, dp) + int_root(longint'(k) <<< vr_pkg::FRAC_BITS));
    for (int c = 0; c < 3; c++) begin
      o = q_round(eta * iv[c] - s * nv[c]);
      if (o > omax) o = omax;
      if (o < omin) o = omin;
      case (c)
        0: r.out_x = o[vr_pkg::WIDTH-1:0];
        1: r.out_y = o[vr_pkg::WIDTH-1:0];
        default: r.out_z = o[vr_pkg::WIDTH-1:0];
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: random gap, then hold the item until it is taken
  // ---------------------------------------------------------------------
  task automatic send_ray(vr_pkg::vec_item_t v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      vec_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vec       <= v;
    vec_valid <= 1'b1;
    do @(posedge clk); while (vec_stall);
    expected_rays.push_back(predict_refraction(v));
    rays_sent++;
  endtask

  task automatic stop_sending();
    vec_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic vr_pkg::vec_item_t make_ray(int ix, int iy, int iz,
                                                 int nx, int ny, int nz, int eta);
    vr_pkg::vec_item_t v;
    v.inc_x = ix[15:0]; v.inc_y = iy[15:0]; v.inc_z = iz[15:0];
    v.nrm_x = nx[15:0]; v.nrm_y = ny[15:0]; v.nrm_z = nz[15:0];
    v.ratio = eta[14:0];
    return v;
  endfunction

  // mostly near-unit components so k lands on both sides of zero; some raw
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0, 1:    return 16'($urandom_range(0, 65535));
      2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic vr_pkg::vec_item_t rand_ray();
    vr_pkg::vec_item_t v;
    v.inc_x = rand_comp(); v.inc_y = rand_comp(); v.inc_z = rand_comp();
    v.nrm_x = rand_comp(); v.nrm_y = rand_comp(); v.nrm_z = rand_comp();
    case ($urandom_range(0, 5))
      0:       v.ratio = 15'($urandom_range(0, 32767));
      1:       v.ratio = $urandom_range(0, 1) ? 15'h7fff : 15'h0;
      default: v.ratio = 15'($urandom_range(2048, 8192));  // eta 0.5 .. 2.0
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stall before each result, one long hold on request
  // ---------------------------------------------------------------------
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        ray_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = no_gaps ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        ray_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      ray_stall <= 1'b0;
      do @(posedge clk); while (!ray_valid);
    end
  end

  // result checker: compare against the oldest prediction
  always @(posedge clk) begin
    vr_pkg::ray_item_t want;
    if (!rst && ray_valid && !ray_stall) begin
      if (expected_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected ray: x=%h y=%h z=%h tir=%b",
                   ray.out_x, ray.out_y, ray.out_z, ray.tir);
      end else begin
        want = expected_rays.pop_front();
        rays_checked++;
        if (want.tir) tir_seen++;
        if (ray !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ray %0d: expected x=%h y=%h z=%h tir=%b, %s",
                     rays_checked, want.out_x, want.out_y, want.out_z, want.tir,
                     $sformatf("got x=%h y=%h z=%h tir=%b",
                               ray.out_x, ray.out_y, ray.out_z, ray.tir));
        end
      end
    end
  end

  // watchdog: no item moving on either side for too long
  always @(posedge clk) begin
    if ((vec_valid && !vec_stall) || (ray_valid && !ray_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("vector_refract_core_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_corners();
    // straight through: eta 1, ray along -n, so out = i
    send_ray(make_ray(0, 0, -4096, 0, 0, 4096, 4096));
    // all zero
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
    // eta zero: k = 1, out = -n
    send_ray(make_ray(1234, -77, 4096, 0, 4096, 0, 0));
    // grazing at eta 2: k < 0, total internal reflection
    send_ray(make_ray(4096, 0, 0, 0, 0, 4096, 8192));
    // k exactly zero: d = 0, eta = 1
    send_ray(make_ray(4096, 0, 0, 0, 0, 4096, 4096));
    // k barely positive and barely negative around the critical angle
    send_ray(make_ray(4096, 0, 0, 0, 0, 4096, 4095));
    send_ray(make_ray(4096, 0, 0, 0, 0, 4096, 4097));
    // field extremes: intermediates and outputs saturate
    send_ray(make_ray(32767, 32767, 32767, -32768, -32768, -32768, 32767));
    send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 32767));
    send_ray(make_ray(32767, -32768, 32767, 32767, -32768, 32767, 0));
    send_ray(make_ray(-32768, 32767, -32768, 32767, 32767, 32767, 1));
    send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    // oblique unit-ish rays, eta below and above one
    send_ray(make_ray(2896, 0, -2896, 0, 0, 4096, 3072));
    send_ray(make_ray(2896, 0, -2896, 0, 0, 4096, 6144));
    send_ray(make_ray(-1, 1, -1, 1, -1, 1, 16384));
    send_ray(make_ray(2048, -2048, 2048, -2048, 2048, -2048, 2048));
  endtask

  task automatic test_streaming();
    no_gaps = 1'b1;
    repeat (150) send_ray(rand_ray());
    no_gaps = 1'b0;
  endtask

  task automatic test_random(int n);
    repeat (n) send_ray(rand_ray());
  endtask

  // result side held long while items keep coming: pipe fills, input stalls
  task automatic test_backpressure();
    no_gaps     = 1'b1;
    hold_cycles = 200;
    repeat (80) send_ray(rand_ray());
    no_gaps = 1'b0;
  endtask

  // sender waits for the pipe to drain completely, then resumes
  task automatic test_drain_pause();
    stop_sending();
    wait (expected_rays.size() == 0);
    @(posedge clk);
    repeat (100) send_ray(rand_ray());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_streaming();
    test_random(700);
    test_backpressure();
    test_drain_pause();
    test_random(700);
    stop_sending();
    wait (expected_rays.size() == 0);
    repeat (FLUSH_WAIT) @(posedge clk);
    $display("sent %0d rays, checked %0d results (%0d with total internal reflection)",
             rays_sent, rays_checked, tir_seen);
    $display("covered corners, streaming, random gaps, long output hold, drain pause");
    if (mismatches == 0 && expected_rays.size() == 0) begin
      $display("vector_refract_core_test OK");
    end else begin
      $display("%0d mismatches, %0d rays missing", mismatches, expected_rays.size());
      $display("vector_refract_core_test NOT OK");
    end
    $finish;
  end

endmodule
